[sv/tstl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the timestamped signal trace recorder.
package tstl_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [1:0] OP_CLR_BIT = 2'd0;
	localparam logic [1:0] OP_SET_BIT = 2'd1;
	localparam logic [1:0] OP_TGL_BIT = 2'd2;
	localparam logic [1:0] OP_LOAD    = 2'd3;

	localparam logic [4:0] STAMP_W_RESET = 5'd28;
	localparam int         ENTRY_W       = 32;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  bit_op;
		logic [7:0]  op_value;
		logic        use_earlier;
		logic [31:0] earlier_stamp;
		logic [6:0]  read_index;
	} item_t;

	typedef struct packed {
		logic [31:0] now_stamp;
		logic        recorded;
		logic [31:0] entry_data;
		logic [7:0]  entry_count;
	} result_t;

	typedef struct packed {
		logic        fits;
		logic [31:0] entry;
	} evt_t;

endpackage

[sv/tstl_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tstl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/tstl_entry_calc.sv]
`timescale 1ns / 1ps
// Event entry builder: stamp correction, fit check, pattern update and packing.
module tstl_entry_calc (
	input  logic [31:0]     last_entry,
	input  logic [63:0]     elapsed,
	input  logic [31:0]     tick_lo,
	input  logic [4:0]      stamp_width,
	input  tstl_pkg::item_t item,
	output tstl_pkg::evt_t  evt
);

	logic [31:0] back;
	logic [63:0] stamp;
	logic [63:0] hi_mask;
	logic [31:0] pat;
	logic [31:0] mask;
	logic [31:0] pat_new;

	always_comb begin
		back    = tick_lo - item.earlier_stamp;
		stamp   = item.use_earlier ? (elapsed - {32'd0, back}) : elapsed;
		hi_mask = ~((64'd1 << stamp_width) - 64'd1);
		pat     = last_entry >> stamp_width;
		mask    = (item.op_value < 8'd32) ? (32'd1 << item.op_value[4:0]) : 32'd0;
		unique case (item.bit_op)
			tstl_pkg::OP_CLR_BIT: pat_new = pat & ~mask;
			tstl_pkg::OP_SET_BIT: pat_new = pat | mask;
			tstl_pkg::OP_TGL_BIT: pat_new = pat ^ mask;
			tstl_pkg::OP_LOAD:    pat_new = {24'd0, item.op_value};
			default:              pat_new = pat;
		endcase
		evt.fits  = ((stamp & hi_mask) == 64'd0);
		evt.entry = (pat_new << stamp_width) | stamp[31:0];
	end

endmodule

[sv/timestamped_signal_trace_log.sv]
`timescale 1ns / 1ps
// Top level of the timestamped signal trace recorder.
//
//   channel   | handshake             | data
//   ----------+-----------------------+------------------------------
//   command   | start / busy          | item   (tstl_pkg::item_t)
//   result    | done (strobe)         | result (tstl_pkg::result_t)
//   config    | cfg_valid / cfg_ready | cfg_data (stamp width)
//
// One command word per cycle; busy stays low. Every result is strobed on done
// in the cycle after its command is taken. A read uses the registered read of the
// trace RAM, which is issued on the accepting edge. The last written
// entry is also held in a register, so an event needs no RAM read.
// Reset clears the counters, sets the write index to one and the stamp width to
// 28; entry zero always reads as zero. The receiver cannot stall.
module timestamped_signal_trace_log #(
	parameter int LOG_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tstl_pkg::item_t     item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data,
	output logic                done,
	output tstl_pkg::result_t   result
);

	localparam int AW  = $clog2(LOG_DEPTH);
	localparam int WIW = $clog2(LOG_DEPTH + 1);
	localparam logic [WIW-1:0] DEPTH_W = WIW'(LOG_DEPTH);
	localparam logic [WIW-1:0] WI_ONE  = WIW'(1);

	logic [63:0]         tick_q;
	logic [63:0]         elapsed_q;
	logic [WIW-1:0]      wi_q;
	logic [31:0]         last_q;
	logic [4:0]          stamp_width_q;
	logic                done_q;
	logic                rd_s1;
	logic                rd_zero_s1;
	tstl_pkg::result_t   res_q;

	logic                accept;
	logic                is_rd;
	logic                room;
	logic                rec;
	logic [63:0]         tick_d;
	logic [WIW-1:0]      wi_d;
	logic [15:0]         wi_ext;
	logic [15:0]         rd_ext;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [31:0]         rdata;
	tstl_pkg::evt_t      evt;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign is_rd     = accept && (item.cmd == tstl_pkg::CMD_READ);
	assign room      = (wi_q < DEPTH_W);
	assign rec       = accept && (item.cmd == tstl_pkg::CMD_EVENT) && room && evt.fits;
	assign rd_ext    = 16'(item.read_index);
	assign raddr     = rd_ext[AW-1:0];
	assign waddr     = wi_q[AW-1:0];

	always_comb begin
		tick_d = tick_q;
		wi_d   = wi_q;
		if (accept) begin
			unique case (item.cmd)
				tstl_pkg::CMD_TICK:  tick_d = tick_q + 64'd1;
				tstl_pkg::CMD_CLEAR: wi_d = WI_ONE;
				tstl_pkg::CMD_EVENT: if (rec) wi_d = wi_q + WI_ONE;
				tstl_pkg::CMD_READ:  wi_d = wi_q;
				default:             wi_d = wi_q;
			endcase
		end
		wi_ext = 16'(wi_d);
	end

	tstl_entry_calc u_calc (
		.last_entry  (last_q),
		.elapsed     (elapsed_q),
		.tick_lo     (tick_q[31:0]),
		.stamp_width (stamp_width_q),
		.item        (item),
		.evt         (evt)
	);

	tstl_ram #(
		.WIDTH (tstl_pkg::ENTRY_W),
		.DEPTH (LOG_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (rec),
		.waddr (waddr),
		.wdata (evt.entry),
		.re    (is_rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= 64'd0;
			elapsed_q     <= 64'd0;
			wi_q          <= WI_ONE;
			last_q        <= 32'd0;
			stamp_width_q <= tstl_pkg::STAMP_W_RESET;
			done_q        <= 1'b0;
			rd_s1         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				stamp_width_q <= cfg_data;
			end
			done_q <= accept;
			rd_s1  <= is_rd;
			tick_q <= tick_d;
			wi_q   <= wi_d;
			if (accept && item.cmd == tstl_pkg::CMD_TICK) begin
				elapsed_q <= elapsed_q + 64'd1;
			end else if (accept && item.cmd == tstl_pkg::CMD_CLEAR) begin
				elapsed_q <= 64'd0;
				last_q    <= 32'd0;
			end else if (rec) begin
				last_q <= evt.entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.now_stamp   <= tick_d[31:0];
			res_q.recorded    <= rec;
			res_q.entry_data  <= rec ? evt.entry : 32'd0;
			res_q.entry_count <= wi_ext[7:0];
			rd_zero_s1        <= (rd_ext >= 16'(LOG_DEPTH)) || (rd_ext == 16'd0);
		end
	end

	always_comb begin
		result = res_q;
		if (rd_s1) begin
			result.entry_data = rd_zero_s1 ? 32'd0 : rdata;
		end
	end

	assign done = done_q;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result strobe without a taken command");

	a_wi_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wi_q >= WI_ONE) && (wi_q <= DEPTH_W))
		else $error("write index out of range");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec |-> (wi_q < DEPTH_W) && (wi_q != '0))
		else $error("store write outside the log");

	a_rec_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		rec |=> (wi_q == $past(wi_q) + WI_ONE) && done && result.recorded)
		else $error("append did not advance the write index");

endmodule
